/* sv/double_ended_queue_macros.svh */
// Assertion helpers used by the queue datapath.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("queue check failed");

// Next-cycle implication, checked out of reset.
`define DQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("queue check failed");

`endif

/* sv/dq_pkg.sv */
package dq_pkg;

  localparam int unsigned DQ_DEPTH     = 1024;
  localparam int unsigned DQ_WORD_BITS = 32;
  localparam int unsigned OP_W         = 3;
  localparam int unsigned STAT_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_QUERY      = 3'd4
  } dq_op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_e;

  typedef enum logic {
    DQ_IDLE,
    DQ_RESP
  } dq_state_e;

  typedef enum logic [1:0] {
    SLOT_TAIL,       // one past the back word
    SLOT_BACK,       // the back word
    SLOT_HEAD_PREV,  // one before the front word
    SLOT_HEAD        // the front word
  } dq_slot_e;

  typedef enum logic [1:0] {
    PTR_KEEP,
    PTR_INC,
    PTR_DEC
  } dq_step_e;

  typedef struct packed {
    logic       load;
    logic       mem_we;
    logic       mem_re;
    dq_slot_e   slot_sel;
    dq_step_e   head_op;
    dq_step_e   count_op;
    dq_status_e status;
    logic       pop_ok;
  } dq_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } dq_stat_t;

endpackage

/* sv/dq_in_if.sv */
interface dq_in_if import dq_pkg::*; #(
  parameter int unsigned WORD_BITS = DQ_WORD_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [WORD_BITS-1:0] push_word;

  modport source (output valid, output operation, output push_word, input ready);
  modport sink   (input valid, input operation, input push_word, output ready);
endinterface

/* sv/dq_out_if.sv */
interface dq_out_if import dq_pkg::*; #(
  parameter int unsigned WORD_BITS = DQ_WORD_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] pop_word;
  logic [STAT_W-1:0]    status;
  logic                 queue_empty;

  modport source (output valid, output pop_word, output status, output queue_empty,
                  input ready);
  modport sink   (input valid, input pop_word, input status, input queue_empty,
                  output ready);
endinterface

/* sv/dq_ctrl.sv */
module dq_ctrl import dq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] operation_i,
  input  logic            out_ready_i,
  input  dq_stat_t        stat_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output dq_cmd_t         cmd_o
);

  dq_state_e state_q, state_d;
  logic      accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    // a held result frees the slot in the cycle it is taken
    in_ready_o  = (state_q == DQ_IDLE) || out_ready_i;
    out_valid_o = (state_q == DQ_RESP);
    accept      = in_valid_i && in_ready_o;

    state_d = state_q;
    unique case (state_q)
      DQ_IDLE: begin
        if (accept) state_d = DQ_RESP;
      end
      DQ_RESP: begin
        if (accept)           state_d = DQ_RESP;
        else if (out_ready_i) state_d = DQ_IDLE;
      end
      default: state_d = DQ_IDLE;
    endcase

    cmd_o          = '0;
    cmd_o.load     = accept;
    cmd_o.slot_sel = SLOT_HEAD;
    cmd_o.head_op  = PTR_KEEP;
    cmd_o.count_op = PTR_KEEP;
    cmd_o.status   = ST_OK;
    if (accept) begin
      unique case (dq_op_e'(operation_i))
        OP_PUSH_BACK: begin
          if (stat_i.full) begin
            cmd_o.status = ST_FULL;
          end else begin
            cmd_o.mem_we   = 1'b1;
            cmd_o.slot_sel = SLOT_TAIL;
            cmd_o.count_op = PTR_INC;
          end
        end
        OP_POP_BACK: begin
          if (stat_i.empty) begin
            cmd_o.status = ST_EMPTY;
          end else begin
            cmd_o.mem_re   = 1'b1;
            cmd_o.pop_ok   = 1'b1;
            cmd_o.slot_sel = SLOT_BACK;
            cmd_o.count_op = PTR_DEC;
          end
        end
        OP_PUSH_FRONT: begin
          if (stat_i.full) begin
            cmd_o.status = ST_FULL;
          end else begin
            cmd_o.mem_we   = 1'b1;
            cmd_o.slot_sel = SLOT_HEAD_PREV;
            cmd_o.head_op  = PTR_DEC;
            cmd_o.count_op = PTR_INC;
          end
        end
        OP_POP_FRONT: begin
          if (stat_i.empty) begin
            cmd_o.status = ST_EMPTY;
          end else begin
            cmd_o.mem_re   = 1'b1;
            cmd_o.pop_ok   = 1'b1;
            cmd_o.slot_sel = SLOT_HEAD;
            cmd_o.head_op  = PTR_INC;
            cmd_o.count_op = PTR_DEC;
          end
        end
        default: begin
          // query and unused codes leave the queue alone
        end
      endcase
    end
  end

endmodule

/* sv/dq_datapath.sv */
`include "double_ended_queue_macros.svh"

module dq_datapath import dq_pkg::*; #(
  parameter int unsigned DEPTH     = DQ_DEPTH,
  parameter int unsigned WORD_BITS = DQ_WORD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dq_cmd_t              cmd_i,
  input  logic [WORD_BITS-1:0] push_word_i,
  output dq_stat_t             stat_o,
  output logic [WORD_BITS-1:0] pop_word_o,
  output logic [STAT_W-1:0]    status_o,
  output logic                 queue_empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W:0]   DEPTH_X = (CNT_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST    = PTR_W'(DEPTH - 1);

  logic [WORD_BITS-1:0] word_store_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;
  logic [PTR_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [STAT_W-1:0]    status_q;
  logic                 pop_ok_q;
  logic                 empty_q;

  logic [CNT_W:0]   tail_sum, back_sum;
  logic [PTR_W-1:0] tail_slot, back_slot, head_prev, head_next, slot;

  // head < DEPTH and count <= DEPTH, so one subtract wraps the sum
  always_comb begin
    tail_sum  = (CNT_W + 1)'(head_q) + {1'b0, count_q};
    back_sum  = tail_sum - 1'b1;
    tail_slot = (tail_sum >= DEPTH_X) ? PTR_W'(tail_sum - DEPTH_X) : PTR_W'(tail_sum);
    back_slot = (back_sum >= DEPTH_X) ? PTR_W'(back_sum - DEPTH_X) : PTR_W'(back_sum);
    head_prev = (head_q == '0) ? LAST : head_q - 1'b1;
    head_next = (head_q == LAST) ? '0 : head_q + 1'b1;

    unique case (cmd_i.slot_sel)
      SLOT_TAIL:      slot = tail_slot;
      SLOT_BACK:      slot = back_slot;
      SLOT_HEAD_PREV: slot = head_prev;
      SLOT_HEAD:      slot = head_q;
      default:        slot = head_q;
    endcase

    unique case (cmd_i.head_op)
      PTR_INC: head_d = head_next;
      PTR_DEC: head_d = head_prev;
      default: head_d = head_q;
    endcase

    unique case (cmd_i.count_op)
      PTR_INC: count_d = count_q + 1'b1;
      PTR_DEC: count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase

    stat_o.empty = (count_q == '0);
    stat_o.full  = (count_q == DEPTH_C);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) word_store_q[slot] <= push_word_i;
    if (cmd_i.mem_re) rdata_q <= word_store_q[slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.load) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q <= cmd_i.status;
      pop_ok_q <= cmd_i.pop_ok;
      empty_q  <= (count_d == '0);
    end
  end

  assign pop_word_o    = pop_ok_q ? rdata_q : '0;
  assign status_o      = status_q;
  assign queue_empty_o = empty_q;

  `DQ_ASSERT_IMPL(a_count_range, 1'b1, count_q <= DEPTH_C && head_q <= LAST)
  `DQ_ASSERT_IMPL(a_one_port_access, 1'b1, !(cmd_i.mem_we && cmd_i.mem_re))
  `DQ_ASSERT_IMPL(a_pop_needs_word, cmd_i.mem_re, !stat_o.empty && cmd_i.pop_ok)
  `DQ_ASSERT_IMPL(a_push_needs_room, cmd_i.mem_we, !stat_o.full && cmd_i.status == ST_OK)
  `DQ_ASSERT_NEXT(a_empty_flag, cmd_i.load, empty_q == (count_q == '0))

endmodule

/* sv/double_ended_queue.sv */
// Double-ended queue of words in a ring of DEPTH entries. Each transfer on in_i carries one
// operation (push back, pop back, push front, pop front, query empty; other codes act as a
// query) and gives exactly one transfer on out_o: the popped word (zero unless a pop
// succeeded), a status (ok, empty on a pop from an empty queue, full on a rejected push) and
// whether the queue is empty afterwards. The result appears the cycle after the item is
// taken, because the store is a single-port memory with a registered read; in_i.ready stays
// high while a result is held and out_o.ready is high, so one item per cycle is sustained and
// a stalled output holds one result and stops the input. No clearing pass runs after reset.
module double_ended_queue import dq_pkg::*; #(
  parameter int unsigned DEPTH     = DQ_DEPTH,
  parameter int unsigned WORD_BITS = DQ_WORD_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_in_if.sink    in_i,
  dq_out_if.source out_o
);

  dq_cmd_t  cmd;
  dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .operation_i (in_i.operation),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  dq_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .push_word_i   (in_i.push_word),
    .stat_o        (stat),
    .pop_word_o    (out_o.pop_word),
    .status_o      (out_o.status),
    .queue_empty_o (out_o.queue_empty)
  );

endmodule

/* tb/dq_checker.sv */
module dq_checker import dq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dq_in_if            in_mon,
  dq_out_if           out_mon,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DQ_WORD_BITS-1:0] pop_word;
    dq_status_e              status;
    logic                    queue_empty;
  } dq_result_t;

  // shadow copy of the ring
  logic [DQ_WORD_BITS-1:0] word_ring [DQ_DEPTH];
  int unsigned             ring_head;
  int unsigned             ring_fill;
  dq_result_t              expected_q [$];
  int unsigned             result_idx;

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t ns: result %0d %s: expected 0x%0h, got 0x%0h",
             $time, result_idx, what, want, got);
    fail_count_o++;
  endtask

  function automatic dq_result_t apply_item(input logic [OP_W-1:0] op,
                                            input logic [DQ_WORD_BITS-1:0] word);
    dq_result_t res;
    res = '{pop_word: '0, status: ST_OK, queue_empty: 1'b0};
    case (op)
      OP_PUSH_BACK: begin
        if (ring_fill == DQ_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          word_ring[(ring_head + ring_fill) % DQ_DEPTH] = word;
          ring_fill++;
        end
      end
      OP_POP_BACK: begin
        if (ring_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          ring_fill--;
          res.pop_word = word_ring[(ring_head + ring_fill) % DQ_DEPTH];
        end
      end
      OP_PUSH_FRONT: begin
        if (ring_fill == DQ_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          ring_head = (ring_head + DQ_DEPTH - 1) % DQ_DEPTH;
          word_ring[ring_head] = word;
          ring_fill++;
        end
      end
      OP_POP_FRONT: begin
        if (ring_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.pop_word = word_ring[ring_head];
          ring_head = (ring_head + 1) % DQ_DEPTH;
          ring_fill--;
        end
      end
      default: ;  // query and spare codes leave the ring alone
    endcase
    res.queue_empty = (ring_fill == 0);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track_transfers
    dq_result_t want;
    if (!rst_ni) begin
      ring_head = 0;
      ring_fill = 0;
      expected_q.delete();
      outstanding_o <= 0;
    end else begin
      // results first: a result never belongs to an item taken at the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transfer, pop_word", '0, out_mon.pop_word);
        end else begin
          want = expected_q.pop_front();
          if (out_mon.pop_word !== want.pop_word)
            report_mismatch("pop_word", want.pop_word, out_mon.pop_word);
          if (out_mon.status !== want.status)
            report_mismatch("status", want.status, out_mon.status);
          if (out_mon.queue_empty !== want.queue_empty)
            report_mismatch("queue_empty", want.queue_empty, out_mon.queue_empty);
        end
        result_idx++;
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(apply_item(in_mon.operation, in_mon.push_word));
      outstanding_o <= expected_q.size();
    end
  end

endmodule

/* tb/tb_double_ended_queue.sv */
module tb_double_ended_queue import dq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned LIMIT_NS    = 5_000_000;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned fill_guess;
  bit          in_idle_on;
  bit          out_stall_on;
  bit          hold_off_req;

  dq_in_if  in_bus ();
  dq_out_if out_bus ();

  double_ended_queue dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  dq_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [OP_W-1:0] pick_op(input int unsigned push_pct,
                                              input int unsigned pop_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct)
      return ($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (r < push_pct + pop_pct)
      return ($urandom_range(0, 1) != 0) ? OP_POP_BACK : OP_POP_FRONT;
    if (r < 98)
      return OP_QUERY;
    // spare codes above the query
    return OP_W'(OP_QUERY) + OP_W'($urandom_range(1, 3));
  endfunction

  // offer one item and return at the edge where it transfers
  task automatic send_item(input logic [OP_W-1:0] op, input logic [DQ_WORD_BITS-1:0] word);
    if (in_idle_on && $urandom_range(0, 9) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.push_word <= word;
    do @(posedge clk); while (!in_bus.ready);
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: if (fill_guess < DQ_DEPTH) fill_guess++;
      OP_POP_BACK, OP_POP_FRONT:   if (fill_guess > 0) fill_guess--;
      default: ;
    endcase
  endtask

  task automatic send_random(input int unsigned push_pct, input int unsigned pop_pct);
    send_item(pick_op(push_pct, pop_pct), DQ_WORD_BITS'($urandom()));
  endtask

  task automatic wait_all_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    out_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_bus.ready <= 1'b1;
      end else if (out_stall_on && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.operation <= OP_QUERY;
    in_bus.push_word <= '0;
    fill_guess   = 0;
    in_idle_on   = 1'b0;
    out_stall_on = 1'b0;
    hold_off_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pops, spare codes, word extremes, head wrap below slot zero
    send_item(OP_POP_BACK, '0);
    send_item(OP_POP_FRONT, '1);
    send_item(OP_QUERY, '1);
    send_item(OP_W'(OP_QUERY) + OP_W'(1), '1);
    send_item(OP_W'(OP_QUERY) + OP_W'(2), '0);
    send_item(OP_W'(OP_QUERY) + OP_W'(3), '1);
    send_item(OP_PUSH_BACK, '0);
    send_item(OP_PUSH_BACK, '1);
    send_item(OP_PUSH_FRONT, 32'ha5a5_a5a5);
    send_item(OP_PUSH_FRONT, 32'h5a5a_5a5a);
    send_item(OP_QUERY, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_BACK, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_BACK, '0);
    send_item(OP_POP_BACK, '0);
    send_item(OP_PUSH_FRONT, 32'h0000_0001);
    send_item(OP_POP_BACK, '0);
    send_item(OP_PUSH_BACK, 32'h8000_0000);
    send_item(OP_POP_FRONT, '0);

    // shallow traffic, empty often
    in_idle_on   = 1'b1;
    out_stall_on = 1'b1;
    repeat (150) send_random(fill_guess < 4 ? 55 : 45, 45);
    wait_all_results();

    // fill to capacity; the long hold-off lands early so the input backs up
    hold_off_req = 1'b1;
    while (fill_guess < DQ_DEPTH) send_random(94, 3);

    // hover at the full mark
    repeat (40) send_random(50, 45);
    wait_all_results();

    // closing stretch without idling
    in_idle_on   = 1'b0;
    out_stall_on = 1'b0;
    repeat (40) send_random(40, 55);
    wait_all_results();
    repeat (4) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/dq_pkg.sv
sv/dq_in_if.sv
sv/dq_out_if.sv
sv/dq_ctrl.sv
sv/dq_datapath.sv
sv/double_ended_queue.sv
tb/dq_checker.sv
tb/tb_double_ended_queue.sv
